// ===== hdl/pfb_pkg.sv =====
// ----------------------------------------------------------------------------
// pfb_pkg: shared types and constants
// Command codes, register indexes, controller states, field widths and
// reset values for the page frame buffer blitter.
// ----------------------------------------------------------------------------
package pfb_pkg;

  // default screen geometry
  localparam int PFB_SCREEN_COLUMNS = 128;
  localparam int PFB_SCREEN_PAGES   = 8;

  // field widths
  localparam int CMD_W    = 2;
  localparam int PIX_W    = 8;
  localparam int RPAGE_W  = 3;
  localparam int RCOL_W   = 7;
  localparam int SX_W     = 7;
  localparam int SY_W     = 6;
  localparam int BW_W     = 8;
  localparam int BH_W     = 7;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 8;

  // register reset values
  localparam logic [BW_W-1:0] BW_RESET = BW_W'(8);
  localparam logic [BH_W-1:0] BH_RESET = BH_W'(8);

  // rows per page / band
  localparam int BAND_ROWS = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_BLIT    = 2'd0,
    CMD_READ    = 2'd1,
    CMD_CLEAR   = 2'd2,
    CMD_RESTART = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_X       = 2'd0,
    CFG_START_Y       = 2'd1,
    CFG_BITMAP_WIDTH  = 2'd2,
    CFG_BITMAP_HEIGHT = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_MERGE0,
    ST_MERGE1,
    ST_READ,
    ST_CLEAR,
    ST_RESP
  } state_t;

endpackage

// ===== hdl/pfb_if.sv =====
// ----------------------------------------------------------------------------
// pfb_in_if / pfb_out_if: request and result channels
// Valid/ready channels carrying one request or one result per transfer.
// ----------------------------------------------------------------------------
interface pfb_in_if import pfb_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [PIX_W-1:0]   pixel_bits;
  logic [RPAGE_W-1:0] read_page;
  logic [RCOL_W-1:0]  read_column;

  modport source (output valid, command, pixel_bits, read_page, read_column,
                  input ready);
  modport sink   (input valid, command, pixel_bits, read_page, read_column,
                  output ready);
endinterface

interface pfb_out_if import pfb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] read_data;
  logic             byte_written;
  logic             blit_done;

  modport source (output valid, read_data, byte_written, blit_done,
                  input ready);
  modport sink   (input valid, read_data, byte_written, blit_done,
                  output ready);
endinterface

// ===== hdl/pfb_store.sv =====
// ----------------------------------------------------------------------------
// pfb_store: frame store RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module pfb_store import pfb_pkg::*; #(
  parameter int DEPTH  = PFB_SCREEN_COLUMNS * PFB_SCREEN_PAGES,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [PIX_W-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [PIX_W-1:0]  rd_data
);

  logic [PIX_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/page_framebuffer_blit.sv =====
// ----------------------------------------------------------------------------
// page_framebuffer_blit: monochrome page frame store with bitmap blitter
// Controller, blit counters and config registers around the frame store RAM.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan carries one request: blit next bitmap byte, read a store byte,
//   clear the store, or restart the blit. out_chan returns exactly one result
//   per request, in order. Config registers are written on cfg_we with
//   cfg_index/cfg_wdata, by the user only while the block is idle (unchecked).
// Sequence (accept edge to result loaded into the output register):
//   clipped blit, restart: IDLE, RESP; blit into one page: IDLE, MERGE0,
//   RESP; blit into two pages: IDLE, MERGE0, MERGE1, RESP; read: IDLE,
//   READ, RESP; clear: IDLE, CLEAR over every store byte, RESP. One request
//   is in flight at a time; each page byte of a blit is read, merged and
//   written back through the single read port of the RAM.
// Reset: counters and config registers go to their reset values, then a
//   clearing pass writes zero to every store byte (DEPTH bytes, 1024 at the
//   default geometry), one per cycle; in_chan.ready stays low meanwhile.
// Stall: the result sits in the output register until taken; a new request
//   is accepted meanwhile, and its result waits until the register frees.
// ----------------------------------------------------------------------------
module page_framebuffer_blit import pfb_pkg::*; #(
  parameter int SCREEN_COLUMNS = PFB_SCREEN_COLUMNS,
  parameter int SCREEN_PAGES   = PFB_SCREEN_PAGES
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata,
  pfb_in_if.sink               in_chan,
  pfb_out_if.source            out_chan
);

  localparam int DEPTH  = SCREEN_COLUMNS * SCREEN_PAGES;
  localparam int ADDR_W = $clog2(DEPTH);

  // config registers
  logic [SX_W-1:0] start_x_r;
  logic [SY_W-1:0] start_y_r;
  logic [BW_W-1:0] bitmap_width_r;
  logic [BH_W-1:0] bitmap_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_x_r       <= '0;
      start_y_r       <= '0;
      bitmap_width_r  <= BW_RESET;
      bitmap_height_r <= BH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_START_X:       start_x_r       <= cfg_wdata[SX_W-1:0];
        CFG_START_Y:       start_y_r       <= cfg_wdata[SY_W-1:0];
        CFG_BITMAP_WIDTH:  bitmap_width_r  <= cfg_wdata[BW_W-1:0];
        CFG_BITMAP_HEIGHT: bitmap_height_r <= cfg_wdata[BH_W-1:0];
      endcase
    end
  end

  // controller state
  state_t state_r, state_nxt;
  logic [ADDR_W-1:0] clr_addr_r, clr_addr_nxt;
  logic [BW_W-1:0]   count_r, count_nxt;      // column inside band
  logic [BH_W-1:0]   band_r, band_nxt;        // first bitmap row of band

  // per-request payload
  logic [PIX_W-1:0]  bits_r, bits_nxt;
  logic [2:0]        ofs_r, ofs_nxt;
  logic [ADDR_W-1:0] a0_r, a0_nxt, a1_r, a1_nxt;
  logic              second_r, second_nxt;
  logic              rd_hit_r, rd_hit_nxt;
  logic [PIX_W-1:0]  res_data_r, res_data_nxt;
  logic              res_written_r, res_written_nxt;
  logic              res_done_r, res_done_nxt;

  // output register
  logic              out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0]  out_data_r, out_data_nxt;
  logic              out_written_r, out_written_nxt;
  logic              out_done_r, out_done_nxt;

  // RAM port
  logic              wr_en, rd_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [PIX_W-1:0]  wr_data, rd_data;

  pfb_store #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // blit placement, from registers only
  logic [8:0]        blit_col;
  logic [7:0]        blit_row;
  logic [4:0]        blit_page;
  logic              blit_hit;
  logic              blit_second;
  logic [ADDR_W-1:0] blit_a0, blit_a1;

  assign blit_col    = {2'b0, start_x_r} + {1'b0, count_r};
  assign blit_row    = {2'b0, start_y_r} + {1'b0, band_r};
  assign blit_page   = blit_row[7:3];
  assign blit_hit    = (blit_col < 9'(SCREEN_COLUMNS)) && (blit_page < 5'(SCREEN_PAGES));
  assign blit_second = blit_hit && (start_y_r[2:0] != 3'd0) &&
                       ({1'b0, blit_page} + 6'd1 < 6'(SCREEN_PAGES));
  assign blit_a0 = ADDR_W'(32'(blit_page) * 32'(SCREEN_COLUMNS) + 32'(blit_col));
  assign blit_a1 = ADDR_W'((32'(blit_page) + 32'd1) * 32'(SCREEN_COLUMNS)
                           + 32'(blit_col));

  // counter advance
  logic [8:0] count_inc;
  logic [7:0] band_inc;
  assign count_inc = {1'b0, count_r} + 9'd1;
  assign band_inc  = {1'b0, band_r} + 8'(BAND_ROWS);

  // read placement
  logic              read_hit;
  logic [ADDR_W-1:0] read_addr;
  assign read_hit  = ({2'b0, in_chan.read_page} < 5'(SCREEN_PAGES)) &&
                     ({2'b0, in_chan.read_column} < 9'(SCREEN_COLUMNS));
  assign read_addr = ADDR_W'(32'(in_chan.read_page) * 32'(SCREEN_COLUMNS)
                             + 32'(in_chan.read_column));

  // merge: shifted byte spans two pages, low half to page, high to next page
  logic [15:0]      shifted, mask;
  logic [PIX_W-1:0] merged0, merged1;
  assign shifted = 16'(bits_r) << ofs_r;
  assign mask    = 16'h00ff << ofs_r;
  assign merged0 = (rd_data & ~mask[7:0])  | shifted[7:0];
  assign merged1 = (rd_data & ~mask[15:8]) | shifted[15:8];

  logic out_free;
  assign out_free = !out_valid_r || out_chan.ready;

  always_comb begin
    state_nxt       = state_r;
    clr_addr_nxt    = clr_addr_r;
    count_nxt       = count_r;
    band_nxt        = band_r;
    bits_nxt        = bits_r;
    ofs_nxt         = ofs_r;
    a0_nxt          = a0_r;
    a1_nxt          = a1_r;
    second_nxt      = second_r;
    rd_hit_nxt      = rd_hit_r;
    res_data_nxt    = res_data_r;
    res_written_nxt = res_written_r;
    res_done_nxt    = res_done_r;
    out_valid_nxt   = out_valid_r && !out_chan.ready;
    out_data_nxt    = out_data_r;
    out_written_nxt = out_written_r;
    out_done_nxt    = out_done_r;
    in_chan.ready   = 1'b0;
    wr_en           = 1'b0;
    wr_addr         = '0;
    wr_data         = '0;
    rd_en           = 1'b0;
    rd_addr         = '0;

    unique case (state_r)
      ST_INIT, ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr_r;
        if (clr_addr_r == ADDR_W'(DEPTH - 1)) begin
          state_nxt = (state_r == ST_INIT) ? ST_IDLE : ST_RESP;
        end else begin
          clr_addr_nxt = clr_addr_r + ADDR_W'(1);
        end
      end

      ST_IDLE: begin
        in_chan.ready = 1'b1;
        if (in_chan.valid) begin
          res_data_nxt    = '0;
          res_written_nxt = 1'b0;
          res_done_nxt    = 1'b0;
          unique case (cmd_t'(in_chan.command))
            CMD_BLIT: begin
              bits_nxt        = in_chan.pixel_bits;
              ofs_nxt         = start_y_r[2:0];
              a0_nxt          = blit_a0;
              a1_nxt          = blit_a1;
              second_nxt      = blit_second;
              res_written_nxt = blit_hit;
              // advance column / band; wrap to start when bitmap ends
              if (count_inc >= {1'b0, bitmap_width_r}) begin
                count_nxt = '0;
                if (band_inc >= {1'b0, bitmap_height_r}) begin
                  band_nxt     = '0;
                  res_done_nxt = 1'b1;
                end else begin
                  band_nxt = band_inc[BH_W-1:0];
                end
              end else begin
                count_nxt = count_inc[BW_W-1:0];
              end
              if (blit_hit) begin
                rd_en     = 1'b1;
                rd_addr   = blit_a0;
                state_nxt = ST_MERGE0;
              end else begin
                state_nxt = ST_RESP;
              end
            end
            CMD_READ: begin
              rd_hit_nxt = read_hit;
              rd_en      = read_hit;
              rd_addr    = read_addr;
              state_nxt  = ST_READ;
            end
            CMD_CLEAR: begin
              clr_addr_nxt = '0;
              state_nxt    = ST_CLEAR;
            end
            CMD_RESTART: begin
              count_nxt = '0;
              band_nxt  = '0;
              state_nxt = ST_RESP;
            end
          endcase
        end
      end

      ST_MERGE0: begin
        wr_en   = 1'b1;
        wr_addr = a0_r;
        wr_data = merged0;
        if (second_r) begin
          rd_en     = 1'b1;
          rd_addr   = a1_r;
          state_nxt = ST_MERGE1;
        end else begin
          state_nxt = ST_RESP;
        end
      end

      ST_MERGE1: begin
        wr_en     = 1'b1;
        wr_addr   = a1_r;
        wr_data   = merged1;
        state_nxt = ST_RESP;
      end

      ST_READ: begin
        res_data_nxt = rd_hit_r ? rd_data : '0;
        state_nxt    = ST_RESP;
      end

      ST_RESP: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_data_nxt    = res_data_r;
          out_written_nxt = res_written_r;
          out_done_nxt    = res_done_r;
          state_nxt       = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      clr_addr_r  <= '0;
      count_r     <= '0;
      band_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      count_r     <= count_nxt;
      band_r      <= band_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    bits_r        <= bits_nxt;
    ofs_r         <= ofs_nxt;
    a0_r          <= a0_nxt;
    a1_r          <= a1_nxt;
    second_r      <= second_nxt;
    rd_hit_r      <= rd_hit_nxt;
    res_data_r    <= res_data_nxt;
    res_written_r <= res_written_nxt;
    res_done_r    <= res_done_nxt;
    out_data_r    <= out_data_nxt;
    out_written_r <= out_written_nxt;
    out_done_r    <= out_done_nxt;
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.read_data    = out_data_r;
  assign out_chan.byte_written = out_written_r;
  assign out_chan.blit_done    = out_done_r;

endmodule
